// ===== rtl/core/encoder_speed_tolerance_check_core_defines.svh =====
// Assertion macros for the encoder speed tolerance check core.
// Each macro takes a label, an antecedent, a consequent and a message.
`ifndef ENCODER_SPEED_TOLERANCE_CHECK_CORE_DEFINES_SVH
`define ENCODER_SPEED_TOLERANCE_CHECK_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define ESC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define ESC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ESC_ASSERT_NOW(lbl, ante, cons, msg)
`define ESC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/core/esc_pkg.sv =====
`default_nettype none

package esc_pkg;

  localparam int CountWidth = 48;

  // Tick scale 6e11 = 60e6 us/min * 1e4 ratio scale
  localparam int TickW = 40;
  localparam logic [TickW-1:0] TickScale = 40'd600000000000;
  localparam int NumW = CountWidth + TickW;

  localparam int UsecW  = 24;
  localparam int CprW   = 16;
  localparam int RatioW = 20;
  localparam int TolW   = 7;
  localparam int CmdW   = 17;
  localparam int RpmW   = 32;
  localparam int P1W    = UsecW + CprW;
  localparam int DivW   = P1W + RatioW;
  localparam int RemW   = DivW + 1;
  localparam int CmpW   = (NumW > DivW + RpmW) ? NumW : DivW + RpmW;
  localparam int CntW   = $clog2(TickW);

  localparam int QDepth = 2;

  localparam logic [CountWidth-1:0] TicksMin = CountWidth'(20);
  localparam logic [7:0] Pct100 = 8'd100;

  localparam logic [1:0] RotCw  = 2'd1;
  localparam logic [1:0] RotCcw = 2'd2;

  localparam logic [1:0] RegTol   = 2'd0;
  localparam logic [1:0] RegCpr   = 2'd1;
  localparam logic [1:0] RegRatio = 2'd2;

  // Window bound arithmetic: cmd * (100 +/- tol) and its divide by 100
  localparam int MagW = 25;
  localparam int BndW = 19;
  localparam int RecipW = 26;
  localparam logic [RecipW-1:0] Div100K = 26'd42949673;

  typedef enum logic [1:0] {
    ST_NOT_CHECKED = 2'd0,
    ST_TOO_FEW     = 2'd1,
    ST_IN_TOL      = 2'd2,
    ST_OUT_TOL     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    KIND_SKIP,
    KIND_FEW,
    KIND_MEASURE
  } kind_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LOAD,
    BK_MUL,
    BK_BIG,
    BK_DIV,
    BK_CMP
  } back_state_e;

  typedef struct packed {
    logic [TolW-1:0]   tol;
    logic [CprW-1:0]   cpr;
    logic [RatioW-1:0] ratio;
  } cfg_t;

  typedef struct packed {
    kind_e                 kind;
    logic                  neg;
    logic [CountWidth-1:0] mag;
    logic [UsecW-1:0]      usec;
    logic [CmdW-1:0]       cmd;
    logic                  ccw;
  } item_t;

  typedef struct packed {
    status_e         status;
    logic [RpmW-1:0] rpm;
  } res_t;

  // Floor of m / 100 by reciprocal multiply, exact for m below 2^MagW
  function automatic logic [BndW-1:0] div100(input logic [MagW-1:0] m);
    logic [MagW+RecipW-1:0] p;
    p = (MagW+RecipW)'(m) * (MagW+RecipW)'(Div100K);
    return p[32 +: BndW];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/esc_front.sv =====
`default_nettype none

module esc_front (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  input  wire logic                           q_full_i,
  input  wire logic signed [47:0]             encoder_count_i,
  input  wire logic [esc_pkg::UsecW-1:0]      interval_us_i,
  input  wire logic [esc_pkg::CmdW-1:0]       commanded_rpm_i,
  input  wire logic [1:0]                     rotation_i,
  input  wire logic                           speed_known_i,
  input  wire esc_pkg::cfg_t                  cfg_i,
  output logic                                q_push_o,
  output esc_pkg::item_t                      q_item_o
);
  import esc_pkg::*;

  logic [CountWidth-1:0] prev_count_q, prev_count_d;
  logic [63:0]           cnt_ext;
  logic [CountWidth-1:0] cnt;
  logic [CountWidth-1:0] diff;
  logic [CountWidth-1:0] mag;
  logic                  neg;
  logic                  checked;
  logic                  zero_div;

  assign cnt_ext  = 64'(encoder_count_i);
  assign cnt      = cnt_ext[CountWidth-1:0];
  assign diff     = cnt - prev_count_q;
  assign neg      = diff[CountWidth-1];
  assign mag      = neg ? (~diff + 1'b1) : diff;
  assign checked  = speed_known_i && (rotation_i == RotCw || rotation_i == RotCcw);
  assign zero_div = (interval_us_i == '0) || (cfg_i.cpr == '0) || (cfg_i.ratio == '0);
  assign q_push_o = in_valid_i && !q_full_i;

  always_comb begin
    q_item_o.neg  = neg;
    q_item_o.mag  = mag;
    q_item_o.usec = interval_us_i;
    q_item_o.cmd  = commanded_rpm_i;
    q_item_o.ccw  = (rotation_i == RotCcw);
    if (!checked) begin
      q_item_o.kind = KIND_SKIP;
    end else if (mag < TicksMin || zero_div) begin
      q_item_o.kind = KIND_FEW;
    end else begin
      q_item_o.kind = KIND_MEASURE;
    end
  end

  // Advance the stored count on every checked sample
  always_comb begin
    prev_count_d = prev_count_q;
    if (q_push_o && checked) begin
      prev_count_d = cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_count_q <= '0;
    end else begin
      prev_count_q <= prev_count_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/esc_queue.sv =====
`default_nettype none

module esc_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire esc_pkg::item_t wdata_i,
  input  wire logic           pop_i,
  output esc_pkg::item_t      rdata_o,
  output logic                full_o,
  output logic                empty_o
);
  import esc_pkg::*;

  localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int CntQW = $clog2(QDepth + 1);

  item_t            mem_q [QDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntQW-1:0] count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (count_q == CntQW'(QDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/esc_back.sv =====
`default_nettype none

module esc_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           q_empty_i,
  input  wire esc_pkg::item_t q_item_i,
  output logic                q_pop_o,
  input  wire esc_pkg::cfg_t  cfg_i,
  input  wire logic           res_ready_i,
  output logic                res_valid_o,
  output esc_pkg::res_t       res_o
);
  import esc_pkg::*;

  localparam int SbW = RpmW + 2;

  back_state_e         state_q, state_d;
  item_t               item_q, item_d;
  logic [P1W-1:0]      p1_q, p1_d;
  logic [DivW-1:0]     div_q, div_d;
  logic [NumW-1:0]     acc_q, acc_d;
  logic [RemW-1:0]     rem_q, rem_d;
  logic [RpmW-1:0]     lo_q, lo_d;
  logic [RpmW-1:0]     quo_q, quo_d;
  logic                big_q, big_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [MagW-1:0]     ma_q, ma_d;
  logic [MagW-1:0]     mb_q, mb_d;
  logic                a_neg_q, a_neg_d;
  logic [RpmW-1:0]     last_rpm_q, last_rpm_d;

  logic [7:0]          tol_lo;
  logic [7:0]          tol_hi;
  logic [RemW:0]       sh;
  logic [RemW:0]       sh_sub;
  logic                ge;
  logic [RpmW-1:0]     mq;
  logic [RpmW-1:0]     meas;
  logic [BndW-1:0]     b1_mag;
  logic [BndW-1:0]     b2_mag;
  logic signed [SbW-1:0] b1;
  logic signed [SbW-1:0] b2;
  logic signed [SbW-1:0] lob;
  logic signed [SbW-1:0] hib;
  logic signed [SbW-1:0] meas_s;
  logic                in_tol;

  // Window factors |100 - tol| and 100 + tol
  assign tol_lo = ({1'b0, cfg_i.tol} > Pct100) ? ({1'b0, cfg_i.tol} - Pct100)
                                                : (Pct100 - {1'b0, cfg_i.tol});
  assign tol_hi = Pct100 + {1'b0, cfg_i.tol};

  // Restoring divide step
  assign sh     = {rem_q, lo_q[RpmW-1]};
  assign ge     = sh >= (RemW+1)'(div_q);
  assign sh_sub = sh - (RemW+1)'(div_q);

  // Saturate the quotient into signed 32 bits
  always_comb begin
    if (!item_q.neg) begin
      mq = (big_q || quo_q[RpmW-1]) ? {1'b0, {(RpmW-1){1'b1}}} : quo_q;
      meas = mq;
    end else begin
      mq = (big_q || quo_q > {1'b1, {(RpmW-1){1'b0}}}) ? {1'b1, {(RpmW-1){1'b0}}} : quo_q;
      meas = ~mq + 1'b1;
    end
  end

  assign b1_mag = div100(ma_q);
  assign b2_mag = div100(mb_q);
  assign b1 = (item_q.ccw ^ a_neg_q) ? -$signed(SbW'(b1_mag)) : $signed(SbW'(b1_mag));
  assign b2 = item_q.ccw ? -$signed(SbW'(b2_mag)) : $signed(SbW'(b2_mag));
  assign lob = (b1 < b2) ? b1 : b2;
  assign hib = (b1 < b2) ? b2 : b1;
  assign meas_s = $signed({{(SbW-RpmW){meas[RpmW-1]}}, meas});
  assign in_tol = (meas_s >= lob) && (meas_s <= hib);

  always_comb begin
    state_d    = state_q;
    item_d     = item_q;
    p1_d       = p1_q;
    div_d      = div_q;
    acc_d      = acc_q;
    rem_d      = rem_q;
    lo_d       = lo_q;
    quo_d      = quo_q;
    big_d      = big_q;
    cnt_d      = cnt_q;
    ma_d       = ma_q;
    mb_d       = mb_q;
    a_neg_d    = a_neg_q;
    last_rpm_d = last_rpm_q;
    q_pop_o    = 1'b0;
    res_valid_o = 1'b0;
    res_o.status = ST_NOT_CHECKED;
    res_o.rpm    = last_rpm_q;
    case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          case (q_item_i.kind)
            KIND_MEASURE: begin
              q_pop_o = 1'b1;
              item_d  = q_item_i;
              state_d = BK_LOAD;
            end
            KIND_FEW: begin
              res_o.status = ST_TOO_FEW;
              if (res_ready_i) begin
                q_pop_o     = 1'b1;
                res_valid_o = 1'b1;
              end
            end
            default: begin
              res_o.status = ST_NOT_CHECKED;
              if (res_ready_i) begin
                q_pop_o     = 1'b1;
                res_valid_o = 1'b1;
              end
            end
          endcase
        end
      end
      BK_LOAD: begin
        p1_d    = P1W'(item_q.usec) * P1W'(cfg_i.cpr);
        ma_d    = MagW'(item_q.cmd) * MagW'(tol_lo);
        mb_d    = MagW'(item_q.cmd) * MagW'(tol_hi);
        a_neg_d = ({1'b0, cfg_i.tol} > Pct100);
        acc_d   = '0;
        cnt_d   = CntW'(TickW - 1);
        state_d = BK_MUL;
      end
      BK_MUL: begin
        // Shift-add over the scale constant, most significant bit first
        div_d = DivW'(p1_q) * DivW'(cfg_i.ratio);
        acc_d = (acc_q << 1) + (TickScale[cnt_q] ? NumW'(item_q.mag) : NumW'(0));
        if (cnt_q == '0) begin
          state_d = BK_BIG;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      BK_BIG: begin
        big_d   = CmpW'(acc_q) >= CmpW'({div_q, {RpmW{1'b0}}});
        rem_d   = RemW'(acc_q >> RpmW);
        lo_d    = acc_q[RpmW-1:0];
        quo_d   = '0;
        cnt_d   = CntW'(RpmW - 1);
        state_d = BK_DIV;
      end
      BK_DIV: begin
        rem_d = ge ? RemW'(sh_sub) : RemW'(sh);
        quo_d = {quo_q[RpmW-2:0], ge};
        lo_d  = lo_q << 1;
        if (cnt_q == '0) begin
          state_d = BK_CMP;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      BK_CMP: begin
        res_o.status = in_tol ? ST_IN_TOL : ST_OUT_TOL;
        res_o.rpm    = meas;
        if (res_ready_i) begin
          res_valid_o = 1'b1;
          last_rpm_d  = meas;
          state_d     = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BK_IDLE;
      last_rpm_q <= '0;
    end else begin
      state_q    <= state_d;
      last_rpm_q <= last_rpm_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    p1_q    <= p1_d;
    div_q   <= div_d;
    acc_q   <= acc_d;
    rem_q   <= rem_d;
    lo_q    <= lo_d;
    quo_q   <= quo_d;
    big_q   <= big_d;
    cnt_q   <= cnt_d;
    ma_q    <= ma_d;
    mb_q    <= mb_d;
    a_neg_q <= a_neg_d;
  end

endmodule

`default_nettype wire

// ===== rtl/core/encoder_speed_tolerance_check_core.sv =====
// Encoder speed tolerance check.
// Input channel: a queue-style port. A sample word is taken at a rising edge with
// push high and full low. Each word gives the extended encoder count, the elapsed
// microseconds, the commanded rpm, the rotation sense and a speed-known flag.
// Result channel: while empty is low, status, passed and measured_rpm show the
// oldest result; pop high at a rising edge takes it. One result per sample.
// Configuration: APB-style, tolerance at 0x0, counts per rev at 0x4, ratio at 0x8.
// pready is tied high; write only while no sample is in flight.
// With the back end idle and the result slot free, a not-checked or too-few-ticks
// sample goes from the queue straight into the result slot. A measured sample is
// popped into the back end, which forms usec * cpr and the window products, then runs
// the bit-serial multiply by 6e11 while forming the divisor, an overflow compare,
// 32 restoring divide steps and a window compare; the serial multiplier and divider
// take no new sample until then. Unmeasured samples retire one per cycle while the result slot drains.
// A two-word queue between front and back lets samples be taken while the back
// end works; full rises when it holds two.
// Reset clears the stored count and the last measured rpm to zero, the queue,
// the result slot, and loads the register defaults (10, 1024, 10000).
// A stalled receiver holds the result slot; the back end then waits with its
// finished result and the queue fills, after which full holds off new samples.
`default_nettype none

module encoder_speed_tolerance_check_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // sample channel
  input  wire logic                        push,
  output logic                             full,
  input  wire logic signed [47:0]          encoder_count_i,
  input  wire logic [23:0]                 interval_us_i,
  input  wire logic [16:0]                 commanded_rpm_i,
  input  wire logic [1:0]                  rotation_i,
  input  wire logic                        speed_known_i,
  // result channel
  output logic                             empty,
  input  wire logic                        pop,
  output logic [1:0]                       status_o,
  output logic                             passed_o,
  output logic signed [31:0]               measured_rpm_o,
  // configuration
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [3:0]                  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import esc_pkg::*;

`include "encoder_speed_tolerance_check_core_defines.svh"

  cfg_t        cfg_q, cfg_d;
  logic        cfg_wr;
  logic [1:0]  reg_idx;

  logic        q_push;
  item_t       q_wdata;
  item_t       q_rdata;
  logic        q_pop;
  logic        q_full;
  logic        q_empty;

  logic        back_res_valid;
  res_t        back_res;
  logic        res_ready;

  logic        out_valid_q, out_valid_d;
  status_e     status_q, status_d;
  logic [31:0] rpm_q, rpm_d;

  // Configuration registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (reg_idx)
        RegTol:   cfg_d.tol   = pwdata[TolW-1:0];
        RegCpr:   cfg_d.cpr   = pwdata[CprW-1:0];
        RegRatio: cfg_d.ratio = pwdata[RatioW-1:0];
        default:  cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegTol:   prdata = 32'(cfg_q.tol);
      RegCpr:   prdata = 32'(cfg_q.cpr);
      RegRatio: prdata = 32'(cfg_q.ratio);
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tol   <= TolW'(10);
      cfg_q.cpr   <= CprW'(1024);
      cfg_q.ratio <= RatioW'(10000);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: classify the sample, form the tick delta, hold the stored count
  esc_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (push),
    .q_full_i        (q_full),
    .encoder_count_i (encoder_count_i),
    .interval_us_i   (interval_us_i),
    .commanded_rpm_i (commanded_rpm_i),
    .rotation_i      (rotation_i),
    .speed_known_i   (speed_known_i),
    .cfg_i           (cfg_q),
    .q_push_o        (q_push),
    .q_item_o        (q_wdata)
  );

  assign full = q_full;

  esc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // Back: scale, divide, saturate and test against the window
  esc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_item_i    (q_rdata),
    .q_pop_o     (q_pop),
    .cfg_i       (cfg_q),
    .res_ready_i (res_ready),
    .res_valid_o (back_res_valid),
    .res_o       (back_res)
  );

  // Result slot: load when free or being drained this cycle
  assign res_ready = !out_valid_q || pop;

  always_comb begin
    out_valid_d = out_valid_q;
    status_d    = status_q;
    rpm_d       = rpm_q;
    if (pop && out_valid_q) begin
      out_valid_d = 1'b0;
    end
    if (back_res_valid) begin
      out_valid_d = 1'b1;
      status_d    = back_res.status;
      rpm_d       = back_res.rpm;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    rpm_q    <= rpm_d;
  end

  assign empty          = !out_valid_q;
  assign status_o       = status_q;
  assign passed_o       = (status_q == ST_NOT_CHECKED) || (status_q == ST_IN_TOL);
  assign measured_rpm_o = $signed(rpm_q);

  // The back end must never overwrite a result still waiting in the slot
  `ESC_ASSERT_NOW(a_res_slot_free, back_res_valid, !out_valid_q || pop, "result written into occupied slot")
  // The front end must not push into a full queue
  `ESC_ASSERT_NOW(a_no_push_full, q_push, !q_full, "push into full queue")
  // A push without a pop leaves the queue holding a word
  `ESC_ASSERT_NEXT(a_push_fills, q_push && !q_pop, !q_empty, "queue empty after push")

endmodule

`default_nettype wire
